// ===== rtl/ffha_pkg.sv =====
// ffha_pkg: shared types and codes for the first-fit heap allocator
// controller states, datapath commands, command and status structs and result codes
// used by ffha_ctrl, ffha_dp and first_fit_heap_allocator
`default_nettype none

package ffha_pkg;

    localparam int HEAP_W = 26;
    localparam int OFF_W  = 25;
    localparam int STAT_W = 3;

    localparam logic [HEAP_W-1:0] HEAP_RESET = 26'd33554432;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_FIT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_USED = 3'd4;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_A_READ,
        S_A_CHECK,
        S_A_SLOT,
        S_A_SPLIT_CUR,
        S_F_READ,
        S_F_CHECK,
        S_F_BACK,
        S_F_MERGE_B,
        S_F_FWD,
        S_F_MERGE_F,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        C_NONE,
        C_INIT,
        C_CONFIG,
        C_ACCEPT,
        C_A_START,
        C_A_READ,
        C_A_STEP,
        C_A_TAKE,
        C_A_SPLIT_NEW,
        C_A_SPLIT_CUR,
        C_F_START,
        C_F_READ,
        C_F_NEXT,
        C_F_UNTAKE,
        C_F_READ_P,
        C_F_MERGE_B,
        C_F_READ_N,
        C_F_MERGE_F,
        C_F_OK,
        C_FAIL_ZERO,
        C_FAIL_FIT,
        C_FAIL_FULL,
        C_FAIL_REL,
        C_DELIVER
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } ctl_t;

    typedef struct packed {
        logic op_rel;
        logic req_zero;
        logic fit;
        logic split;
        logic at_nil;
        logic slot_done;
        logic slot_found;
        logic match;
        logic scan_last;
        logic back_ok;
        logic fwd_ok;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// first_fit_heap_allocator: first-fit heap block table with split and coalescing
// allocate: walks the block list one block at a time; a split also waits for the
// free-slot scan, which runs alongside the walk and ends at a free slot or the table end
// release: scans table entries in order (up to MAX_BLOCKS), then merges with free
// neighbours; one request at a time, the result waits in an output register
// reset (or a heap_bytes write) rebuilds the table as one free block
`default_nettype none

module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int OFFSET_BITS  = 25
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [ffha_pkg::HEAP_W-1:0]  heap_bytes,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         op,
    input  wire logic [ffha_pkg::HEAP_W-1:0]  request_size,
    input  wire logic [ffha_pkg::OFF_W-1:0]   user_offset,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [ffha_pkg::OFF_W-1:0]        payload_offset,
    output logic [ffha_pkg::STAT_W-1:0]       status
);

    ffha_pkg::ctl_t ctl;
    ffha_pkg::sts_t sts;

    ffha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_valid (cfg_valid),
        .sts       (sts),
        .ctl       (ctl),
        .in_stall  (in_stall),
        .cfg_ready (cfg_ready)
    );

    ffha_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .heap_bytes     (heap_bytes),
        .op             (op),
        .request_size   (request_size),
        .user_offset    (user_offset),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_offset (payload_offset),
        .status         (status)
    );

endmodule

`default_nettype wire

// ===== rtl/ffha_ctrl.sv =====
// ffha_ctrl: sequencer for allocate, release and table initialization
// depends on ffha_pkg; drives datapath commands from datapath status
`default_nettype none

module ffha_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          cfg_valid,
    input  wire ffha_pkg::sts_t sts,
    output ffha_pkg::ctl_t     ctl,
    output logic               in_stall,
    output logic               cfg_ready
);

    ffha_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffha_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cfg_ready = (state_reg == ffha_pkg::S_IDLE);
    assign in_stall  = (state_reg != ffha_pkg::S_IDLE) || cfg_valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffha_pkg::S_INIT:        state_next = ffha_pkg::S_IDLE;
            ffha_pkg::S_IDLE:
            begin
                if (cfg_valid)
                    state_next = ffha_pkg::S_INIT;
                else if (in_valid)
                    state_next = ffha_pkg::S_DISPATCH;
            end
            ffha_pkg::S_DISPATCH:
            begin
                if (sts.op_rel)
                    state_next = ffha_pkg::S_F_READ;
                else if (sts.req_zero)
                    state_next = ffha_pkg::S_DONE;
                else
                    state_next = ffha_pkg::S_A_READ;
            end
            ffha_pkg::S_A_READ:      state_next = ffha_pkg::S_A_CHECK;
            ffha_pkg::S_A_CHECK:
            begin
                if (sts.fit)
                    state_next = sts.split ? ffha_pkg::S_A_SLOT : ffha_pkg::S_DONE;
                else if (sts.at_nil)
                    state_next = ffha_pkg::S_DONE;
                else
                    state_next = ffha_pkg::S_A_READ;
            end
            ffha_pkg::S_A_SLOT:
            begin
                if (sts.slot_done)
                    state_next = sts.slot_found ? ffha_pkg::S_A_SPLIT_CUR
                                                : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_A_SPLIT_CUR: state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_F_READ:      state_next = ffha_pkg::S_F_CHECK;
            ffha_pkg::S_F_CHECK:
            begin
                if (sts.match)
                    state_next = ffha_pkg::S_F_BACK;
                else if (sts.scan_last)
                    state_next = ffha_pkg::S_DONE;
                else
                    state_next = ffha_pkg::S_F_READ;
            end
            ffha_pkg::S_F_BACK:
                state_next = sts.back_ok ? ffha_pkg::S_F_MERGE_B : ffha_pkg::S_F_FWD;
            ffha_pkg::S_F_MERGE_B:   state_next = ffha_pkg::S_F_FWD;
            ffha_pkg::S_F_FWD:
                state_next = sts.fwd_ok ? ffha_pkg::S_F_MERGE_F : ffha_pkg::S_DONE;
            ffha_pkg::S_F_MERGE_F:   state_next = ffha_pkg::S_DONE;
            ffha_pkg::S_DONE:
            begin
                if (sts.out_free)
                    state_next = ffha_pkg::S_IDLE;
            end
            default:                 state_next = ffha_pkg::S_INIT;
        endcase
    end

    always_comb
    begin
        ctl.cmd = ffha_pkg::C_NONE;
        unique case (state_reg)
            ffha_pkg::S_INIT:        ctl.cmd = ffha_pkg::C_INIT;
            ffha_pkg::S_IDLE:
            begin
                if (cfg_valid)
                    ctl.cmd = ffha_pkg::C_CONFIG;
                else if (in_valid)
                    ctl.cmd = ffha_pkg::C_ACCEPT;
            end
            ffha_pkg::S_DISPATCH:
            begin
                if (sts.op_rel)
                    ctl.cmd = ffha_pkg::C_F_START;
                else if (sts.req_zero)
                    ctl.cmd = ffha_pkg::C_FAIL_ZERO;
                else
                    ctl.cmd = ffha_pkg::C_A_START;
            end
            ffha_pkg::S_A_READ:      ctl.cmd = ffha_pkg::C_A_READ;
            ffha_pkg::S_A_CHECK:
            begin
                if (sts.fit)
                    ctl.cmd = sts.split ? ffha_pkg::C_NONE : ffha_pkg::C_A_TAKE;
                else if (sts.at_nil)
                    ctl.cmd = ffha_pkg::C_FAIL_FIT;
                else
                    ctl.cmd = ffha_pkg::C_A_STEP;
            end
            ffha_pkg::S_A_SLOT:
            begin
                if (sts.slot_done)
                    ctl.cmd = sts.slot_found ? ffha_pkg::C_A_SPLIT_NEW
                                             : ffha_pkg::C_FAIL_FULL;
            end
            ffha_pkg::S_A_SPLIT_CUR: ctl.cmd = ffha_pkg::C_A_SPLIT_CUR;
            ffha_pkg::S_F_READ:      ctl.cmd = ffha_pkg::C_F_READ;
            ffha_pkg::S_F_CHECK:
            begin
                if (sts.match)
                    ctl.cmd = ffha_pkg::C_F_UNTAKE;
                else if (sts.scan_last)
                    ctl.cmd = ffha_pkg::C_FAIL_REL;
                else
                    ctl.cmd = ffha_pkg::C_F_NEXT;
            end
            ffha_pkg::S_F_BACK:
                ctl.cmd = sts.back_ok ? ffha_pkg::C_F_READ_P : ffha_pkg::C_NONE;
            ffha_pkg::S_F_MERGE_B:   ctl.cmd = ffha_pkg::C_F_MERGE_B;
            ffha_pkg::S_F_FWD:
                ctl.cmd = sts.fwd_ok ? ffha_pkg::C_F_READ_N : ffha_pkg::C_F_OK;
            ffha_pkg::S_F_MERGE_F:   ctl.cmd = ffha_pkg::C_F_MERGE_F;
            ffha_pkg::S_DONE:
            begin
                if (sts.out_free)
                    ctl.cmd = ffha_pkg::C_DELIVER;
            end
            default:                 ctl.cmd = ffha_pkg::C_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ffha_dp.sv =====
// ffha_dp: block table memories, present/taken bits, walk and scan registers
// depends on ffha_pkg; executes one ffha_ctrl command per cycle
`default_nettype none

module ffha_dp #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int OFFSET_BITS  = 25
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ffha_pkg::ctl_t               ctl,
    output ffha_pkg::sts_t                    sts,
    input  wire logic [ffha_pkg::HEAP_W-1:0]  heap_bytes,
    input  wire logic                         op,
    input  wire logic [ffha_pkg::HEAP_W-1:0]  request_size,
    input  wire logic [ffha_pkg::OFF_W-1:0]   user_offset,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [ffha_pkg::OFF_W-1:0]        payload_offset,
    output logic [ffha_pkg::STAT_W-1:0]       status
);

    localparam int IDXW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LNKW  = $clog2(MAX_BLOCKS + 1);
    localparam int HW    = ffha_pkg::HEAP_W;
    localparam int NW    = HW + 1;
    localparam int WIDEW = 33;
    localparam logic [LNKW-1:0]  NIL      = LNKW'(MAX_BLOCKS);
    localparam logic [IDXW-1:0]  LAST_IDX = IDXW'(MAX_BLOCKS - 1);
    localparam logic [WIDEW-1:0] OFF_MASK = (WIDEW'(1) << OFFSET_BITS) - WIDEW'(1);
    localparam logic [WIDEW-1:0] OFF_SPAN = WIDEW'(1) << OFFSET_BITS;

    logic [HW-1:0]   start_mem [MAX_BLOCKS];
    logic [HW-1:0]   bytes_mem [MAX_BLOCKS];
    logic [LNKW-1:0] fwd_mem   [MAX_BLOCKS];
    logic [LNKW-1:0] bwd_mem   [MAX_BLOCKS];

    logic [MAX_BLOCKS-1:0] present_reg, present_next;
    logic [MAX_BLOCKS-1:0] taken_reg, taken_next;
    logic [HW-1:0]   heap_reg;
    logic            op_reg;
    logic [HW-1:0]   req_reg;
    logic [ffha_pkg::OFF_W-1:0] off_reg;
    logic [IDXW-1:0] cur_reg;
    logic [IDXW-1:0] idx_reg;
    logic [LNKW-1:0] scan_reg;
    logic            found_reg;
    logic [IDXW-1:0] slot_reg;
    logic [LNKW-1:0] p_reg;
    logic [LNKW-1:0] cfwd_reg;
    logic [HW-1:0]   cbytes_reg;
    logic [HW-1:0]   start_q, bytes_q;
    logic [LNKW-1:0] fwd_q, bwd_q;
    logic [ffha_pkg::OFF_W-1:0]  res_off_reg;
    logic [ffha_pkg::STAT_W-1:0] res_stat_reg;
    logic            out_valid_reg;
    logic [ffha_pkg::OFF_W-1:0]  out_off_reg;
    logic [ffha_pkg::STAT_W-1:0] out_stat_reg;

    logic            rd_en;
    logic [IDXW-1:0] rd_addr;
    logic            we_start, we_bytes, we_fwd, we_bwd;
    logic [IDXW-1:0] wa_start, wa_bytes, wa_fwd, wa_bwd;
    logic [HW-1:0]   wd_start, wd_bytes;
    logic [LNKW-1:0] wd_fwd, wd_bwd;

    logic [NW-1:0]    need;
    logic [NW-1:0]    need_hdr;
    logic [WIDEW-1:0] pay_wide;
    logic [ffha_pkg::OFF_W-1:0] pay_off;
    logic [WIDEW-1:0] heap_sat;
    logic [HW-1:0]    sum_b;
    logic [IDXW-1:0]  p_idx, cfwd_idx, fwdq_idx, scan_idx;

    assign need     = NW'(req_reg) + NW'(HEADER_BYTES);
    assign need_hdr = need + NW'(HEADER_BYTES);
    assign pay_wide = (WIDEW'(start_q) + WIDEW'(HEADER_BYTES)) & OFF_MASK;
    assign pay_off  = pay_wide[ffha_pkg::OFF_W-1:0];
    assign heap_sat = (WIDEW'(heap_bytes) > OFF_SPAN) ? OFF_SPAN : WIDEW'(heap_bytes);
    assign sum_b    = cbytes_reg + bytes_q;
    assign p_idx    = p_reg[IDXW-1:0];
    assign cfwd_idx = cfwd_reg[IDXW-1:0];
    assign fwdq_idx = fwd_q[IDXW-1:0];
    assign scan_idx = scan_reg[IDXW-1:0];

    // status back to the sequencer
    always_comb
    begin
        sts.op_rel     = op_reg;
        sts.req_zero   = (req_reg == '0);
        sts.fit        = present_reg[cur_reg] && !taken_reg[cur_reg]
                         && (NW'(bytes_q) > need);
        sts.split      = (NW'(bytes_q) > need_hdr);
        sts.at_nil     = (fwd_q == NIL);
        sts.slot_done  = found_reg || (scan_reg == NIL);
        sts.slot_found = found_reg;
        sts.match      = present_reg[idx_reg] && taken_reg[idx_reg]
                         && (pay_wide == WIDEW'(off_reg));
        sts.scan_last  = (idx_reg == LAST_IDX);
        sts.back_ok    = (p_reg != NIL) && present_reg[p_idx] && !taken_reg[p_idx];
        sts.fwd_ok     = (cfwd_reg != NIL) && present_reg[cfwd_idx]
                         && !taken_reg[cfwd_idx];
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    // memory port control
    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = cur_reg;
        we_start = 1'b0;
        we_bytes = 1'b0;
        we_fwd   = 1'b0;
        we_bwd   = 1'b0;
        wa_start = cur_reg;
        wa_bytes = cur_reg;
        wa_fwd   = cur_reg;
        wa_bwd   = cur_reg;
        wd_start = '0;
        wd_bytes = '0;
        wd_fwd   = NIL;
        wd_bwd   = NIL;
        case (ctl.cmd)
            ffha_pkg::C_INIT:
            begin
                we_start = 1'b1;
                we_bytes = 1'b1;
                we_fwd   = 1'b1;
                we_bwd   = 1'b1;
                wa_start = '0;
                wa_bytes = '0;
                wa_fwd   = '0;
                wa_bwd   = '0;
                wd_bytes = heap_reg;
            end
            ffha_pkg::C_A_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = cur_reg;
            end
            ffha_pkg::C_F_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg;
            end
            ffha_pkg::C_F_READ_P:
            begin
                rd_en   = 1'b1;
                rd_addr = p_idx;
            end
            ffha_pkg::C_F_READ_N:
            begin
                rd_en   = 1'b1;
                rd_addr = cfwd_idx;
            end
            ffha_pkg::C_A_SPLIT_NEW:
            begin
                we_start = 1'b1;
                we_bytes = 1'b1;
                we_fwd   = 1'b1;
                we_bwd   = 1'b1;
                wa_start = slot_reg;
                wa_bytes = slot_reg;
                wa_fwd   = slot_reg;
                wa_bwd   = slot_reg;
                wd_start = start_q + need[HW-1:0];
                wd_bytes = bytes_q - need[HW-1:0];
                wd_fwd   = fwd_q;
                wd_bwd   = LNKW'(cur_reg);
            end
            ffha_pkg::C_A_SPLIT_CUR:
            begin
                we_bytes = 1'b1;
                we_fwd   = 1'b1;
                wa_bytes = cur_reg;
                wa_fwd   = cur_reg;
                wd_bytes = need[HW-1:0];
                wd_fwd   = LNKW'(slot_reg);
                we_bwd   = (fwd_q != NIL);
                wa_bwd   = fwdq_idx;
                wd_bwd   = LNKW'(slot_reg);
            end
            ffha_pkg::C_F_MERGE_B:
            begin
                we_bytes = 1'b1;
                we_fwd   = 1'b1;
                wa_bytes = p_idx;
                wa_fwd   = p_idx;
                wd_bytes = sum_b;
                wd_fwd   = cfwd_reg;
                we_bwd   = (cfwd_reg != NIL);
                wa_bwd   = cfwd_idx;
                wd_bwd   = p_reg;
            end
            ffha_pkg::C_F_MERGE_F:
            begin
                we_bytes = 1'b1;
                we_fwd   = 1'b1;
                wa_bytes = cur_reg;
                wa_fwd   = cur_reg;
                wd_bytes = sum_b;
                wd_fwd   = fwd_q;
                we_bwd   = (fwd_q != NIL);
                wa_bwd   = fwdq_idx;
                wd_bwd   = LNKW'(cur_reg);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_start)
            start_mem[wa_start] <= wd_start;
        if (we_bytes)
            bytes_mem[wa_bytes] <= wd_bytes;
        if (we_fwd)
            fwd_mem[wa_fwd] <= wd_fwd;
        if (we_bwd)
            bwd_mem[wa_bwd] <= wd_bwd;
        if (rd_en)
        begin
            start_q <= start_mem[rd_addr];
            bytes_q <= bytes_mem[rd_addr];
            fwd_q   <= fwd_mem[rd_addr];
            bwd_q   <= bwd_mem[rd_addr];
        end
    end

    always_comb
    begin
        present_next = present_reg;
        taken_next   = taken_reg;
        case (ctl.cmd)
            ffha_pkg::C_INIT:
            begin
                present_next    = '0;
                present_next[0] = 1'b1;
                taken_next      = '0;
            end
            ffha_pkg::C_A_TAKE:      taken_next[cur_reg] = 1'b1;
            ffha_pkg::C_A_SPLIT_NEW:
            begin
                present_next[slot_reg] = 1'b1;
                taken_next[slot_reg]   = 1'b0;
            end
            ffha_pkg::C_A_SPLIT_CUR: taken_next[cur_reg] = 1'b1;
            ffha_pkg::C_F_UNTAKE:    taken_next[idx_reg] = 1'b0;
            ffha_pkg::C_F_MERGE_B:   present_next[cur_reg] = 1'b0;
            ffha_pkg::C_F_MERGE_F:
            begin
                present_next[cfwd_idx] = 1'b0;
                taken_next[cfwd_idx]   = 1'b0;
            end
            default:
            begin
                present_next = present_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= '0;
            taken_reg     <= '0;
            heap_reg      <= ffha_pkg::HEAP_RESET;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            scan_reg      <= '0;
        end
        else
        begin
            present_reg <= present_next;
            taken_reg   <= taken_next;
            if (ctl.cmd == ffha_pkg::C_CONFIG)
                heap_reg <= heap_sat[HW-1:0];
            if (ctl.cmd == ffha_pkg::C_DELIVER)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            // lowest free slot, searched one entry a cycle during the walk
            if (ctl.cmd == ffha_pkg::C_A_START)
            begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end
            else if (!found_reg && (scan_reg != NIL))
            begin
                if (!present_reg[scan_idx])
                    found_reg <= 1'b1;
                else
                    scan_reg <= scan_reg + LNKW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!found_reg)
            slot_reg <= scan_idx;
        case (ctl.cmd)
            ffha_pkg::C_ACCEPT:
            begin
                op_reg  <= op;
                req_reg <= request_size;
                off_reg <= user_offset;
            end
            ffha_pkg::C_A_START:   cur_reg <= '0;
            ffha_pkg::C_A_STEP:    cur_reg <= fwdq_idx;
            ffha_pkg::C_A_TAKE,
            ffha_pkg::C_A_SPLIT_CUR:
            begin
                res_off_reg  <= pay_off;
                res_stat_reg <= ffha_pkg::ST_OK;
            end
            ffha_pkg::C_F_START:   idx_reg <= '0;
            ffha_pkg::C_F_NEXT:    idx_reg <= idx_reg + IDXW'(1);
            ffha_pkg::C_F_UNTAKE:
            begin
                cur_reg    <= idx_reg;
                cbytes_reg <= bytes_q;
                cfwd_reg   <= fwd_q;
                p_reg      <= bwd_q;
            end
            ffha_pkg::C_F_MERGE_B:
            begin
                cur_reg    <= p_idx;
                cbytes_reg <= sum_b;
            end
            ffha_pkg::C_F_MERGE_F,
            ffha_pkg::C_F_OK:
            begin
                res_off_reg  <= '0;
                res_stat_reg <= ffha_pkg::ST_OK;
            end
            ffha_pkg::C_FAIL_ZERO:
            begin
                res_off_reg  <= '0;
                res_stat_reg <= ffha_pkg::ST_ZERO;
            end
            ffha_pkg::C_FAIL_FIT:
            begin
                res_off_reg  <= '0;
                res_stat_reg <= ffha_pkg::ST_NO_FIT;
            end
            ffha_pkg::C_FAIL_FULL:
            begin
                res_off_reg  <= '0;
                res_stat_reg <= ffha_pkg::ST_FULL;
            end
            ffha_pkg::C_FAIL_REL:
            begin
                res_off_reg  <= '0;
                res_stat_reg <= ffha_pkg::ST_NOT_USED;
            end
            ffha_pkg::C_DELIVER:
            begin
                out_off_reg  <= res_off_reg;
                out_stat_reg <= res_stat_reg;
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign payload_offset = out_off_reg;
    assign status         = out_stat_reg;

endmodule

`default_nettype wire
